### rtl/reaction_diffusion_euler_sweep_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shorthand for clocked implication checks used by the sweep logic.
// ----------------------------------------------------------------------------
`ifndef REACTION_DIFFUSION_EULER_SWEEP_ASSERT_SVH
`define REACTION_DIFFUSION_EULER_SWEEP_ASSERT_SVH

// same-cycle implication
`define RDE_ASSERT_IMP(lbl, ck, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define RDE_ASSERT_NXT(lbl, ck, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/rde_pkg.sv
// ----------------------------------------------------------------------------
// rde_pkg
// Shared types, widths and helpers of the reaction-diffusion sweep.
// ----------------------------------------------------------------------------
package rde_pkg;

	localparam int LEVEL_W   = 32;
	localparam int COEF_W    = 31;
	localparam int CIDX_W    = 12;
	localparam int CFG_IDX_W = 3;
	localparam int OPND_W    = 33;
	localparam int SAT_W     = 2 * OPND_W;

	// configuration register map
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_TIME_STEP  = 3'd0,
		REG_CONSUME    = 3'd1,
		REG_SOURCE     = 3'd2,
		REG_DIFFUSION  = 3'd3,
		REG_DAMP_EN    = 3'd4
	} cfg_idx_t;

	// operand pair for the shared Q16.16 multiplier
	typedef struct packed {
		logic signed [OPND_W-1:0] a;
		logic signed [OPND_W-1:0] b;
	} mul_req_t;

	// clamp a wide signed value to the signed 32-bit range
	function automatic logic signed [LEVEL_W-1:0] sat32(input logic signed [SAT_W-1:0] v);
		logic fits;
		fits = (&v[SAT_W-1:LEVEL_W-1]) || !(|v[SAT_W-1:LEVEL_W-1]);
		if (fits)
			sat32 = v[LEVEL_W-1:0];
		else if (v[SAT_W-1])
			sat32 = {1'b1, {(LEVEL_W-1){1'b0}}};
		else
			sat32 = {1'b0, {(LEVEL_W-1){1'b1}}};
	endfunction

endpackage

### rtl/rde_if.sv
// ----------------------------------------------------------------------------
// rde channel interfaces
// Valid/ready channels for cells in and updated levels out.
// ----------------------------------------------------------------------------
interface rde_in_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] level_in;
	logic        [30:0] consumers_in;
	logic               first_cell;
	logic               last_cell;

	modport source (output valid, level_in, consumers_in, first_cell, last_cell,
		input ready);
	modport sink (input valid, level_in, consumers_in, first_cell, last_cell,
		output ready);
endinterface

interface rde_out_if;
	logic               valid;
	logic               ready;
	logic        [11:0] cell_index;
	logic signed [31:0] level_out;
	logic               last_out;

	modport source (output valid, cell_index, level_out, last_out, input ready);
	modport sink (input valid, cell_index, level_out, last_out, output ready);
endinterface

### rtl/reaction_diffusion_euler_sweep.sv
// ----------------------------------------------------------------------------
// reaction_diffusion_euler_sweep
// Streams one explicit Euler step of a 1D reaction-diffusion field over a
// three-cell window, zero-flux edges, saturating Q16.16 arithmetic.
// ----------------------------------------------------------------------------
// Timing: the first result beat follows the cell beat through states ST_M1 to ST_M8.
// Flow: a new cell is taken only in ST_IDLE, after one or two result beats,
//   or at once for a cell that yields nothing; six products are issued in turn
//   on the one shared multiplier (8 compute states) before the output beats.
// Reset: arst_n clears window, position, sequencer and configuration registers; damping on.
`include "reaction_diffusion_euler_sweep_assert.svh"

module reaction_diffusion_euler_sweep #(
	parameter int MAX_CELLS = 4096
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_wr_en,
	input  logic [rde_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [rde_pkg::COEF_W-1:0]       cfg_wdata,
	rde_in_if.sink                           in_ch,
	rde_out_if.source                        out_ch
);
	import rde_pkg::*;

	localparam int PW = $clog2(MAX_CELLS);
	localparam logic [PW-1:0] POS_MAX = PW'(MAX_CELLS - 1);
	localparam logic [PW-1:0] POS_SAT = PW'(MAX_CELLS - 2);
	localparam logic [PW-1:0] STENCIL_START = PW'(2);

	typedef enum logic [10:0] {
		ST_IDLE = 11'b000_0000_0001,
		ST_M1   = 11'b000_0000_0010,
		ST_M2   = 11'b000_0000_0100,
		ST_M3   = 11'b000_0000_1000,
		ST_M4   = 11'b000_0001_0000,
		ST_M5   = 11'b000_0010_0000,
		ST_M6   = 11'b000_0100_0000,
		ST_M7   = 11'b000_1000_0000,
		ST_M8   = 11'b001_0000_0000,
		ST_OUT1 = 11'b010_0000_0000,
		ST_OUT2 = 11'b100_0000_0000
	} state_t;

	state_t state_q;

	// configuration registers
	logic [COEF_W-1:0] dt_q, cons_rate_q, src_q, diff_q;
	logic              damp_en_q;

	// stencil window
	logic signed [LEVEL_W-1:0] two_back_q, one_back_q, left_q;
	logic        [COEF_W-1:0]  cons_one_back_q, n_q;
	logic        [PW-1:0]      pos_q;

	// working registers
	logic signed [LEVEL_W-1:0] lap_q, dd_q, m1_q, kon_q, reac_q, lvl_q;
	logic signed [OPND_W-1:0]  acc_q;
	logic        [PW-1:0]      first_idx_q, sec_idx_q;
	logic                      sec_last_q, two_q;

	logic                      in_fire, out_fire;
	logic        [PW-1:0]      idx_w;
	mul_req_t                  mreq;
	logic signed [LEVEL_W-1:0] mres;
	logic signed [LEVEL_W-1:0] dmp_w;
	logic signed [LEVEL_W+1:0] lap_w, reac_w, new_w;

	assign in_ch.ready = (state_q == ST_IDLE);
	assign in_fire     = in_ch.valid && in_ch.ready;
	assign out_fire    = out_ch.valid && out_ch.ready;
	assign idx_w       = in_ch.first_cell ? '0 : pos_q;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dt_q        <= '0;
			cons_rate_q <= '0;
			src_q       <= '0;
			diff_q      <= '0;
			damp_en_q   <= 1'b1;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_TIME_STEP: dt_q        <= cfg_wdata;
				REG_CONSUME:   cons_rate_q <= cfg_wdata;
				REG_SOURCE:    src_q       <= cfg_wdata;
				REG_DIFFUSION: diff_q      <= cfg_wdata;
				REG_DAMP_EN:   damp_en_q   <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	// window shift and sweep position on each cell beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			two_back_q      <= '0;
			one_back_q      <= '0;
			cons_one_back_q <= '0;
			pos_q           <= '0;
		end else if (in_fire) begin
			two_back_q      <= one_back_q;
			one_back_q      <= in_ch.level_in;
			cons_one_back_q <= in_ch.consumers_in;
			if (in_ch.last_cell)
				pos_q <= '0;
			else if (idx_w < POS_SAT)
				pos_q <= PW'(idx_w + 1'b1);
			else
				pos_q <= POS_MAX;
		end
	end

	// cell snapshot and result index plan
	always_ff @(posedge clk) begin
		if (in_fire) begin
			left_q <= two_back_q;
			n_q    <= cons_one_back_q;
			if (idx_w == STENCIL_START) begin
				first_idx_q <= '0;
				sec_idx_q   <= in_ch.last_cell ? STENCIL_START : PW'(1);
				two_q       <= 1'b1;
			end else begin
				first_idx_q <= PW'(idx_w - 1'b1);
				sec_idx_q   <= idx_w;
				two_q       <= in_ch.last_cell;
			end
			sec_last_q <= in_ch.last_cell;
		end
	end

	// multiplier operand select; o is two_back_q after the shift
	always_comb begin
		mreq.a = $signed({2'b00, dt_q});
		mreq.b = $signed({2'b00, diff_q});
		case (state_q)
			ST_M2: begin
				mreq.a = $signed({2'b00, cons_rate_q});
				mreq.b = OPND_W'(two_back_q);
			end
			ST_M3: begin
				mreq.a = OPND_W'(dd_q);
				mreq.b = OPND_W'(lap_q);
			end
			ST_M4: begin
				mreq.a = OPND_W'(m1_q);
				mreq.b = $signed({2'b00, n_q});
			end
			ST_M5: begin
				mreq.a = OPND_W'(two_back_q);
				mreq.b = $signed({2'b00, src_q});
			end
			ST_M7: begin
				mreq.a = $signed({2'b00, dt_q});
				mreq.b = OPND_W'(reac_q);
			end
			default: ;
		endcase
	end

	rde_mulq u_mulq (
		.clk (clk),
		.req (mreq),
		.res (mres)
	);

	// side arithmetic around the multiplier
	always_comb begin
		lap_w  = (LEVEL_W+2)'(left_q) + (LEVEL_W+2)'(one_back_q)
			- ((LEVEL_W+2)'(two_back_q) <<< 1);
		dmp_w  = damp_en_q ? mres : '0;
		reac_w = $signed({3'b000, src_q}) - (LEVEL_W+2)'(kon_q) - (LEVEL_W+2)'(dmp_w);
		new_w  = (LEVEL_W+2)'(acc_q) + (LEVEL_W+2)'(mres);
	end

	// capture products as they come out
	always_ff @(posedge clk) begin
		case (state_q)
			ST_M1: lap_q  <= sat32(SAT_W'(lap_w));
			ST_M2: dd_q   <= mres;
			ST_M3: m1_q   <= mres;
			ST_M4: acc_q  <= OPND_W'(two_back_q) + OPND_W'(mres);
			ST_M5: kon_q  <= mres;
			ST_M6: reac_q <= sat32(SAT_W'(reac_w));
			ST_M8: lvl_q  <= sat32(SAT_W'(new_w));
			default: ;
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: if (in_fire && idx_w >= STENCIL_START) state_q <= ST_M1;
				ST_M1:   state_q <= ST_M2;
				ST_M2:   state_q <= ST_M3;
				ST_M3:   state_q <= ST_M4;
				ST_M4:   state_q <= ST_M5;
				ST_M5:   state_q <= ST_M6;
				ST_M6:   state_q <= ST_M7;
				ST_M7:   state_q <= ST_M8;
				ST_M8:   state_q <= ST_OUT1;
				ST_OUT1: if (out_fire) state_q <= two_q ? ST_OUT2 : ST_IDLE;
				ST_OUT2: if (out_fire) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// result beats
	assign out_ch.valid      = (state_q == ST_OUT1) || (state_q == ST_OUT2);
	assign out_ch.cell_index = (state_q == ST_OUT2) ? CIDX_W'(sec_idx_q) : CIDX_W'(first_idx_q);
	assign out_ch.level_out  = lvl_q;
	assign out_ch.last_out   = (state_q == ST_OUT2) && sec_last_q;

	`RDE_ASSERT_IMP(a_ready_no_out, clk, arst_n, in_ch.ready, !out_ch.valid, "ready while a result is pending")
	`RDE_ASSERT_NXT(a_second_beat, clk, arst_n, out_fire && (state_q == ST_OUT1) && two_q, out_ch.valid && (out_ch.last_out == sec_last_q), "second result beat missing")
	`RDE_ASSERT_NXT(a_quiet_cell, clk, arst_n, in_fire && (idx_w < STENCIL_START), in_ch.ready, "edge cell did not return to idle")
	`RDE_ASSERT_NXT(a_last_idle, clk, arst_n, out_fire && out_ch.last_out, in_ch.ready && !out_ch.valid, "no idle after final result")

endmodule

### rtl/rde_mulq.sv
// ----------------------------------------------------------------------------
// rde_mulq
// Shared Q16.16 multiplier: registered product, then round half up,
// floor shift by 16 and saturation. Result is valid in the cycle after issue.
// ----------------------------------------------------------------------------
module rde_mulq (
	input  logic                              clk,
	input  rde_pkg::mul_req_t                 req,
	output logic signed [rde_pkg::LEVEL_W-1:0] res
);
	import rde_pkg::*;

	logic signed [SAT_W-1:0] prod_s1;
	logic signed [SAT_W-1:0] rnd;
	logic signed [SAT_W-1:0] shf;

	// product register
	always_ff @(posedge clk) begin
		prod_s1 <= req.a * req.b;
	end

	// round, shift, clamp
	always_comb begin
		rnd = prod_s1 + SAT_W'(32'sd32768);
		shf = rnd >>> 16;
		res = sat32(shf);
	end

endmodule
